// ===== sv/qvr_pkg.sv =====
// shared constants and types for the quaternion vector rotation pipeline
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

   // quaternion components are fixed at 16 signed bits
   localparam int QUAT_W = 16;
   // w^2 - x^2 - y^2 - z^2 lies in [-3 * 2^30, 2^30]
   localparam int SCALE_W = 2 * QUAT_W + 1;

   // defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF = 14;

   // control register port
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAT_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAT_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAT_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAT_W = 3'd3;

   // configured rotation quaternion
   typedef struct packed {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] z;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] x;
   } quat_type;

endpackage

`default_nettype wire

// ===== sv/qvr_front.sv =====
// first two stages: raw products, then scale, dot and cross sums
`timescale 1ns / 1ps
`default_nettype none

module qvr_front #(
   parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
   localparam int PROD_W = COORD_WIDTH + qvr_pkg::QUAT_W,
   localparam int SUM_W = PROD_W + 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire qvr_pkg::quat_type                 quat,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [COORD_WIDTH-1:0]     vec_x,
   input  wire logic signed [COORD_WIDTH-1:0]     vec_y,
   input  wire logic signed [COORD_WIDTH-1:0]     vec_z,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [qvr_pkg::SCALE_W-1:0]     out_scale,
   output logic signed [SUM_W-1:0]                out_dot,
   output logic signed [SUM_W-1:0]                out_cx,
   output logic signed [SUM_W-1:0]                out_cy,
   output logic signed [SUM_W-1:0]                out_cz,
   output logic signed [COORD_WIDTH-1:0]          out_vx,
   output logic signed [COORD_WIDTH-1:0]          out_vy,
   output logic signed [COORD_WIDTH-1:0]          out_vz
);

   localparam int SQ_W = 2 * qvr_pkg::QUAT_W;

   logic s1_valid_ff, s2_valid_ff;
   logic s1_ready, s2_ready;

   // stage 1 products
   logic signed [PROD_W-1:0] xvx_ff, yvy_ff, zvz_ff;
   logic signed [PROD_W-1:0] yvz_ff, zvy_ff, zvx_ff, xvz_ff, xvy_ff, yvx_ff;
   logic signed [SQ_W-1:0]   ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [COORD_WIDTH-1:0] s1_vx_ff, s1_vy_ff, s1_vz_ff;

   // stage 2 sums
   logic signed [qvr_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic signed [SUM_W-1:0] dot_ff, dot_in, cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [COORD_WIDTH-1:0] s2_vx_ff, s2_vy_ff, s2_vz_ff;

   // a stage takes a word when it is empty or its word moves on
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 1: all multiplications
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         xvx_ff   <= quat.x * vec_x;
         yvy_ff   <= quat.y * vec_y;
         zvz_ff   <= quat.z * vec_z;
         yvz_ff   <= quat.y * vec_z;
         zvy_ff   <= quat.z * vec_y;
         zvx_ff   <= quat.z * vec_x;
         xvz_ff   <= quat.x * vec_z;
         xvy_ff   <= quat.x * vec_y;
         yvx_ff   <= quat.y * vec_x;
         ww_ff    <= quat.w * quat.w;
         xx_ff    <= quat.x * quat.x;
         yy_ff    <= quat.y * quat.y;
         zz_ff    <= quat.z * quat.z;
         s1_vx_ff <= vec_x;
         s1_vy_ff <= vec_y;
         s1_vz_ff <= vec_z;
      end
   end

   // stage 2: scalar term, dot product and cross product
   always_comb begin
      scale_in = qvr_pkg::SCALE_W'(ww_ff) - qvr_pkg::SCALE_W'(xx_ff)
               - qvr_pkg::SCALE_W'(yy_ff) - qvr_pkg::SCALE_W'(zz_ff);
      dot_in   = SUM_W'(xvx_ff) + SUM_W'(yvy_ff) + SUM_W'(zvz_ff);
      cx_in    = SUM_W'(yvz_ff) - SUM_W'(zvy_ff);
      cy_in    = SUM_W'(zvx_ff) - SUM_W'(xvz_ff);
      cz_in    = SUM_W'(xvy_ff) - SUM_W'(yvx_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         scale_ff <= scale_in;
         dot_ff   <= dot_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_vz_ff <= s1_vz_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_scale = scale_ff;
   assign out_dot   = dot_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_cz    = cz_ff;
   assign out_vx    = s2_vx_ff;
   assign out_vy    = s2_vy_ff;
   assign out_vz    = s2_vz_ff;

endmodule

`default_nettype wire

// ===== sv/qvr_back.sv =====
// stages three and four: weight the three terms, then add them with rounding half
`timescale 1ns / 1ps
`default_nettype none

module qvr_back #(
   parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF,
   localparam int SUM_W = COORD_WIDTH + qvr_pkg::QUAT_W + 1,
   localparam int ACC_W = (COORD_WIDTH + 38 > 2 * FRAC_BITS + COORD_WIDTH + 2)
                        ? COORD_WIDTH + 38 : 2 * FRAC_BITS + COORD_WIDTH + 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire qvr_pkg::quat_type                 quat,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [qvr_pkg::SCALE_W-1:0] in_scale,
   input  wire logic signed [SUM_W-1:0]           in_dot,
   input  wire logic signed [SUM_W-1:0]           in_cx,
   input  wire logic signed [SUM_W-1:0]           in_cy,
   input  wire logic signed [SUM_W-1:0]           in_cz,
   input  wire logic signed [COORD_WIDTH-1:0]     in_vx,
   input  wire logic signed [COORD_WIDTH-1:0]     in_vy,
   input  wire logic signed [COORD_WIDTH-1:0]     in_vz,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [ACC_W-1:0]                out_acc_x,
   output logic signed [ACC_W-1:0]                out_acc_y,
   output logic signed [ACC_W-1:0]                out_acc_z
);

   localparam int T1_W = qvr_pkg::SCALE_W + COORD_WIDTH;
   localparam int T2_W = SUM_W + qvr_pkg::QUAT_W;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (2 * FRAC_BITS - 1);

   logic s3_valid_ff, s4_valid_ff;
   logic s3_ready, s4_ready;

   logic signed [T1_W-1:0] t1x_ff, t1y_ff, t1z_ff;
   logic signed [T2_W-1:0] t2x_ff, t2y_ff, t2z_ff;
   logic signed [T2_W-1:0] t3x_ff, t3y_ff, t3z_ff;
   logic signed [ACC_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in, acc_z_ff, acc_z_in;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) s3_valid_ff <= in_valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 3: scale * v, dot * u, w * cross (factors of two come later)
   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         t1x_ff <= in_scale * in_vx;
         t1y_ff <= in_scale * in_vy;
         t1z_ff <= in_scale * in_vz;
         t2x_ff <= in_dot * quat.x;
         t2y_ff <= in_dot * quat.y;
         t2z_ff <= in_dot * quat.z;
         t3x_ff <= in_cx * quat.w;
         t3y_ff <= in_cy * quat.w;
         t3z_ff <= in_cz * quat.w;
      end
   end

   // stage 4: exact sum plus half an output lsb
   always_comb begin
      acc_x_in = ACC_W'(t1x_ff) + (ACC_W'(t2x_ff) <<< 1) + (ACC_W'(t3x_ff) <<< 1) + HALF;
      acc_y_in = ACC_W'(t1y_ff) + (ACC_W'(t2y_ff) <<< 1) + (ACC_W'(t3y_ff) <<< 1) + HALF;
      acc_z_in = ACC_W'(t1z_ff) + (ACC_W'(t2z_ff) <<< 1) + (ACC_W'(t3z_ff) <<< 1) + HALF;
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         acc_z_ff <= acc_z_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_acc_x = acc_x_ff;
   assign out_acc_y = acc_y_ff;
   assign out_acc_z = acc_z_ff;

endmodule

`default_nettype wire

// ===== sv/qvr_round.sv =====
// stage five: drop fraction bits, clamp to the coordinate range, hold the result word
`timescale 1ns / 1ps
`default_nettype none

module qvr_round #(
   parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF,
   parameter int ACC_W = COORD_WIDTH + 38
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [ACC_W-1:0]       in_acc_x,
   input  wire logic signed [ACC_W-1:0]       in_acc_y,
   input  wire logic signed [ACC_W-1:0]       in_acc_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z,
   output logic                               out_sat
);

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic sat_ff, sat_in;
   logic signed [ACC_W-1:0] sh_x, sh_y, sh_z;
   logic ovf_x, ovf_y, ovf_z;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // floor shift, then out of range when the upper bits are not all sign
   always_comb begin
      sh_x  = in_acc_x >>> SHIFT;
      sh_y  = in_acc_y >>> SHIFT;
      sh_z  = in_acc_z >>> SHIFT;
      ovf_x = !((&sh_x[ACC_W-1:COORD_WIDTH-1]) || !(|sh_x[ACC_W-1:COORD_WIDTH-1]));
      ovf_y = !((&sh_y[ACC_W-1:COORD_WIDTH-1]) || !(|sh_y[ACC_W-1:COORD_WIDTH-1]));
      ovf_z = !((&sh_z[ACC_W-1:COORD_WIDTH-1]) || !(|sh_z[ACC_W-1:COORD_WIDTH-1]));
      x_in  = ovf_x ? (sh_x[ACC_W-1] ? MINV : MAXV) : sh_x[COORD_WIDTH-1:0];
      y_in  = ovf_y ? (sh_y[ACC_W-1] ? MINV : MAXV) : sh_y[COORD_WIDTH-1:0];
      z_in  = ovf_z ? (sh_z[ACC_W-1] ? MINV : MAXV) : sh_z[COORD_WIDTH-1:0];
      sat_in = ovf_x || ovf_y || ovf_z;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// ===== sv/quaternion_vector_rotate.sv =====
// an accepted req word passes five register stages (s1, s2, s3, s4, round) to reach rsp_tvalid
// throughput: one word per cycle unless rsp stalls; every stage has its own valid and takes
// a word when it is empty or its word moves on, so bubbles close up behind a stalled rsp side
// reset: synchronous, clears all stage valids and sets the quaternion to identity (w = 1.0)
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate #(
   parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF,
   localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // control registers
   input  wire logic                                csr_we,
   input  wire logic [qvr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [qvr_pkg::QUAT_W-1:0]          csr_wdata,
   // input vectors
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [TDATA_W-1:0]                  req_tdata,  // vec_x, vec_y, vec_z
   // rotated vectors
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [TDATA_W-1:0]                       rsp_tdata,  // rot_x, rot_y, rot_z
   output logic                                     rsp_tuser   // saturated
);

   localparam int SUM_W = COORD_WIDTH + qvr_pkg::QUAT_W + 1;
   localparam int ACC_W = (COORD_WIDTH + 38 > 2 * FRAC_BITS + COORD_WIDTH + 2)
                        ? COORD_WIDTH + 38 : 2 * FRAC_BITS + COORD_WIDTH + 2;
   localparam logic [qvr_pkg::QUAT_W-1:0] QUAT_ONE =
      qvr_pkg::QUAT_W'(64'd1 << FRAC_BITS);

   qvr_pkg::quat_type quat_ff;

   logic f_valid, f_ready;
   logic signed [qvr_pkg::SCALE_W-1:0] f_scale;
   logic signed [SUM_W-1:0] f_dot, f_cx, f_cy, f_cz;
   logic signed [COORD_WIDTH-1:0] f_vx, f_vy, f_vz;
   logic b_valid, b_ready;
   logic signed [ACC_W-1:0] b_acc_x, b_acc_y, b_acc_z;
   logic signed [COORD_WIDTH-1:0] rot_x, rot_y, rot_z;

   // quaternion registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
         quat_ff.w <= QUAT_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            qvr_pkg::CSR_QUAT_X: quat_ff.x <= csr_wdata;
            qvr_pkg::CSR_QUAT_Y: quat_ff.y <= csr_wdata;
            qvr_pkg::CSR_QUAT_Z: quat_ff.z <= csr_wdata;
            qvr_pkg::CSR_QUAT_W: quat_ff.w <= csr_wdata;
            default: ;
         endcase
      end
   end

   // products and sums
   qvr_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vec_x     (req_tdata[COORD_WIDTH-1:0]),
      .vec_y     (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .vec_z     (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_scale (f_scale),
      .out_dot   (f_dot),
      .out_cx    (f_cx),
      .out_cy    (f_cy),
      .out_cz    (f_cz),
      .out_vx    (f_vx),
      .out_vy    (f_vy),
      .out_vz    (f_vz)
   );

   // weighted terms and accumulation
   qvr_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_scale  (f_scale),
      .in_dot    (f_dot),
      .in_cx     (f_cx),
      .in_cy     (f_cy),
      .in_cz     (f_cz),
      .in_vx     (f_vx),
      .in_vy     (f_vy),
      .in_vz     (f_vz),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_acc_x (b_acc_x),
      .out_acc_y (b_acc_y),
      .out_acc_z (b_acc_z)
   );

   // rounding, saturation and output register
   qvr_round #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ACC_W      (ACC_W)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_acc_x  (b_acc_x),
      .in_acc_y  (b_acc_y),
      .in_acc_z  (b_acc_z),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (rot_x),
      .out_y     (rot_y),
      .out_z     (rot_z),
      .out_sat   (rsp_tuser)
   );

   // pack the result word, zero padded to whole bytes
   assign rsp_tdata = TDATA_W'({rot_z, rot_y, rot_x});

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the quaternion vector rotation pipeline
`timescale 1ns / 1ps

module tb;

   localparam int COORD_W = qvr_pkg::COORD_WIDTH_DEF;
   localparam int FRAC_W = qvr_pkg::FRAC_BITS_DEF;
   localparam int TDATA_W = ((3 * COORD_W + 7) / 8) * 8;
   localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 112;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 4000;

   // one rotated vector with its clamp flag
   typedef struct {
      logic signed [COORD_W-1:0] rot_x;
      logic signed [COORD_W-1:0] rot_y;
      logic signed [COORD_W-1:0] rot_z;
      logic                      saturated;
   } rotated_vec_type;

   // keeps its own copy of the quaternion and the rotations still owed by the block
   class rotation_checker;
      logic signed [qvr_pkg::QUAT_W-1:0] quat_x;
      logic signed [qvr_pkg::QUAT_W-1:0] quat_y;
      logic signed [qvr_pkg::QUAT_W-1:0] quat_z;
      logic signed [qvr_pkg::QUAT_W-1:0] quat_w;
      rotated_vec_type rotations_due[$];
      int failures;

      function new();
         quat_x = '0;
         quat_y = '0;
         quat_z = '0;
         quat_w = qvr_pkg::QUAT_W'(1 << FRAC_W);
         failures = 0;
      endfunction

      // indexes past quat_w have no register behind them
      function void set_register(logic [qvr_pkg::CSR_INDEX_W-1:0] index,
                                 logic [qvr_pkg::QUAT_W-1:0] value);
         case (index)
            qvr_pkg::CSR_QUAT_X: quat_x = value;
            qvr_pkg::CSR_QUAT_Y: quat_y = value;
            qvr_pkg::CSR_QUAT_Z: quat_z = value;
            qvr_pkg::CSR_QUAT_W: quat_w = value;
            default: ;
         endcase
      endfunction

      // round half up out of the doubled fraction, then clamp to the coordinate range
      function logic signed [COORD_W-1:0] round_clamp(longint acc, inout logic sat);
         longint q;
         q = (acc + (64'sd1 <<< (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
         if (q > COORD_MAX) begin
            q = COORD_MAX;
            sat = 1'b1;
         end else if (q < COORD_MIN) begin
            q = COORD_MIN;
            sat = 1'b1;
         end
         return q[COORD_W-1:0];
      endfunction

      // q v q* = (w^2 - |u|^2) v + 2 (u.v) u + 2 w (u x v), kept exact before rounding
      function void note_vector(logic [TDATA_W-1:0] data);
         longint x, y, z, w, vx, vy, vz, s, d2, w2, cx, cy, cz;
         rotated_vec_type r;
         x = quat_x;
         y = quat_y;
         z = quat_z;
         w = quat_w;
         vx = $signed(data[COORD_W-1:0]);
         vy = $signed(data[2*COORD_W-1:COORD_W]);
         vz = $signed(data[3*COORD_W-1:2*COORD_W]);
         s = w * w - x * x - y * y - z * z;
         d2 = 2 * (x * vx + y * vy + z * vz);
         w2 = 2 * w;
         cx = y * vz - z * vy;
         cy = z * vx - x * vz;
         cz = x * vy - y * vx;
         r.saturated = 1'b0;
         r.rot_x = round_clamp(s * vx + d2 * x + w2 * cx, r.saturated);
         r.rot_y = round_clamp(s * vy + d2 * y + w2 * cy, r.saturated);
         r.rot_z = round_clamp(s * vz + d2 * z + w2 * cz, r.saturated);
         rotations_due.push_back(r);
      endfunction

      // compare one rotated word with the oldest rotation owed
      function void check_result(logic [TDATA_W-1:0] data, logic flag);
         rotated_vec_type exp_r;
         logic signed [COORD_W-1:0] got_x, got_y, got_z;
         got_x = data[COORD_W-1:0];
         got_y = data[2*COORD_W-1:COORD_W];
         got_z = data[3*COORD_W-1:2*COORD_W];
         if (rotations_due.size() == 0) begin
            $display("%0t: unexpected word x %0d y %0d z %0d sat %0d",
                     $time, got_x, got_y, got_z, flag);
            failures++;
            return;
         end
         exp_r = rotations_due.pop_front();
         if (got_x !== exp_r.rot_x) begin
            $display("%0t: rot_x expected %0d got %0d", $time, exp_r.rot_x, got_x);
            failures++;
         end
         if (got_y !== exp_r.rot_y) begin
            $display("%0t: rot_y expected %0d got %0d", $time, exp_r.rot_y, got_y);
            failures++;
         end
         if (got_z !== exp_r.rot_z) begin
            $display("%0t: rot_z expected %0d got %0d", $time, exp_r.rot_z, got_z);
            failures++;
         end
         if (flag !== exp_r.saturated) begin
            $display("%0t: saturated expected %0d got %0d", $time, exp_r.saturated, flag);
            failures++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [qvr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [qvr_pkg::QUAT_W-1:0]      csr_wdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [TDATA_W-1:0]              req_tdata = '0;  // vec_x, vec_y, vec_z
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [TDATA_W-1:0]              rsp_tdata;       // rot_x, rot_y, rot_z
   logic                            rsp_tuser;       // saturated

   rotation_checker rotations = new();

   // receiver pacing, shared with the stimulus process
   bit rsp_idle_on = 1'b1;
   bit long_hold_request = 1'b0;
   int hold_left = 0;

   // directed vectors: zero, both extremes, mixed signs, small values
   logic signed [COORD_W-1:0] probes [0:7][0:2] = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768},
      '{16'sd32767, -16'sd32768, 16'sd1},
      '{-16'sd1, 16'sd0, -16'sd1},
      '{16'sd1234, -16'sd4321, 16'sd100},
      '{16'sd0, 16'sd32767, -16'sd32768},
      '{16'sd16384, -16'sd16384, 16'sd8192}
   };

   quaternion_vector_rotate dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #4_800_000;
      $display("tb NOT OK");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 6) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // rsp side: check accepted words, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rotations.check_result(rsp_tdata, rsp_tuser);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!rsp_idle_on) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            hold_left = gap_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one vector word after an optional gap and wait for it to be taken
   task automatic send_vector(input logic signed [COORD_W-1:0] vx, vy, vz, input bit idle);
      int gap;
      gap = (idle && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vz, vy, vx};
      do @(posedge clock); while (!req_tready);
      rotations.note_vector({vz, vy, vx});
   endtask

   // stop offering and let every owed rotation come back
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (rotations.rotations_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // one register write per cycle; the caller drops csr_we when done
   task automatic write_reg(input logic [qvr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [qvr_pkg::QUAT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      rotations.set_register(index, value);
   endtask

   // load all four components plus a write to an unused index
   task automatic load_quat(input logic [qvr_pkg::QUAT_W-1:0] qx, qy, qz, qw);
      write_reg(qvr_pkg::CSR_QUAT_X, qx);
      write_reg(qvr_pkg::CSR_QUAT_Y, qy);
      write_reg(qvr_pkg::CSR_QUAT_Z, qz);
      write_reg(qvr_pkg::CSR_QUAT_W, qw);
      write_reg(qvr_pkg::CSR_INDEX_W'($urandom_range(qvr_pkg::CSR_QUAT_W + 1,
                                                     (1 << qvr_pkg::CSR_INDEX_W) - 1)),
                qvr_pkg::QUAT_W'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic send_probes(input int first, input int count);
      for (int i = first; i < first + count; i++)
         send_vector(probes[i][0], probes[i][1], probes[i][2], 1'b1);
   endtask

   // random unit quaternion, truncated to Q1.14
   task automatic load_unit_quat();
      real c[4];
      real norm;
      for (int i = 0; i < 4; i++) c[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (norm < 0.001) begin
         c[3] = 1.0;
         norm = 1.0;
      end
      load_quat(qvr_pkg::QUAT_W'($rtoi(c[0] / norm * 16384.0)),
                qvr_pkg::QUAT_W'($rtoi(c[1] / norm * 16384.0)),
                qvr_pkg::QUAT_W'($rtoi(c[2] / norm * 16384.0)),
                qvr_pkg::QUAT_W'($rtoi(c[3] / norm * 16384.0)));
   endtask

   function automatic logic signed [COORD_W-1:0] random_coord(int kind);
      case (kind)
         0: return COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
         1: begin
            case ($urandom_range(0, 3))
               0: return COORD_MAX[COORD_W-1:0];
               1: return COORD_MIN[COORD_W-1:0];
               2: return '1;
               default: return '0;
            endcase
         end
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      int kind;
      bit tx_idle;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity quaternion straight out of reset
      send_probes(0, 8);
      drain();

      // largest positive components: heavy scaling, saturates
      load_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_probes(1, 3);
      drain();
      // most negative components
      load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_probes(3, 3);
      drain();
      // all-zero quaternion gives a zero vector
      load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_probes(5, 2);
      drain();
      // half turn about x
      load_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_probes(4, 3);
      drain();
      // quarter turn about z
      load_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
      send_probes(5, 3);
      drain();
      // non-unit quaternion, scale of four
      load_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
      send_probes(1, 3);
      drain();

      // random phases, each with its own quaternion
      for (int p = 0; p < PHASES; p++) begin
         if (p % 2 == 0) load_unit_quat();
         else load_quat(qvr_pkg::QUAT_W'($urandom), qvr_pkg::QUAT_W'($urandom),
                        qvr_pkg::QUAT_W'($urandom), qvr_pkg::QUAT_W'($urandom));
         tx_idle = (p != 2 && p != 5);
         rsp_idle_on = (p != 5);
         // long rsp hold-off while the sender keeps pushing
         if (p == 2) long_hold_request = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            kind = $urandom_range(0, 9);
            kind = (kind < 6) ? 2 : (kind < 8) ? 0 : 1;
            send_vector(random_coord(kind), random_coord(kind), random_coord(kind), tx_idle);
         end
         drain();
      end

      // final verdict
      if (rotations.rotations_due.size() != 0) begin
         $display("%0t: %0d rotations never returned", $time, rotations.rotations_due.size());
         rotations.failures++;
      end
      if (rotations.failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== quaternion_vector_rotate.f =====
sv/qvr_pkg.sv
sv/qvr_front.sv
sv/qvr_back.sv
sv/qvr_round.sv
sv/quaternion_vector_rotate.sv
tb/tb.sv
